[rtl/core/btb_pkg.sv]
// package for the two-level branch predictor with branch target buffer
// shared types, register indexes and constants; no dependencies
`default_nettype none
package btb_pkg;
    localparam int unsigned PC_W = 32;

    typedef enum logic [2:0] {
        REG_INDEX_BITS  = 3'd0,
        REG_HIST_SIZE   = 3'd1,
        REG_TAG_SIZE    = 3'd2,
        REG_FSM_RESET   = 3'd3,
        REG_GLOBAL_HIST = 3'd4,
        REG_GLOBAL_TBL  = 3'd5,
        REG_SHARE_MODE  = 3'd6,
        REG_NONE        = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        SHARE_NONE = 2'd0,
        SHARE_LOW  = 2'd1,
        SHARE_HIGH = 2'd2,
        SHARE_RSVD = 2'd3
    } t_share;

    typedef enum logic {
        OP_PREDICT = 1'b0,
        OP_UPDATE  = 1'b1
    } t_op;

    // back end sequencing
    typedef enum logic [2:0] {
        ST_SWEEP, ST_IDLE, ST_READ, ST_WRITE, ST_ROWCLR
    } t_back_state;

    typedef struct packed {
        logic        operation;
        logic [31:0] branch_pc;
        logic [31:0] resolved_target;
        logic        resolved_taken;
    } t_in_item;

    typedef struct packed {
        logic        predict_taken;
        logic [31:0] predicted_target;
        logic        flush;
        logic [31:0] branch_count;
        logic [31:0] flush_count;
    } t_out_item;

    typedef struct packed {
        logic [2:0] btb_index_bits;
        logic [3:0] history_size;
        logic [4:0] tag_size;
        logic [1:0] fsm_reset;
        logic       global_history;
        logic       global_table;
        logic [1:0] share_mode;
    } t_cfg;

    localparam logic [PC_W-1:0] PC_STEP = 32'd4;
endpackage
`default_nettype wire

[rtl/core/btb_two_level_branch_predictor.sv]
// top level of the two-level branch predictor with branch target buffer
// depends on btb_pkg, btb_front, btb_back
`default_nettype none
// Queue-like predictor. Push a transaction (predict or update); pop one result
// per transaction. The back end runs one item at a time and takes nothing new
// while a result waits: with results popped at once each item goes through
// issue with counter read, result, then counter write or the result pop, paced
// by the single counter memory port and the one result register. The front
// queue holds two more transactions meanwhile. An update that misses while
// per-entry counter tables are selected also clears that entry's row, one
// counter per cycle, before the counter write.
// After reset and after each configuration write the counter memory is cleared
// while no transaction is taken. Configuration is to be written only while
// idle; the block itself does not enforce it. Any write to a known register
// index clears store and both running counts.
module btb_two_level_branch_predictor #(
    parameter int unsigned BTB_DEPTH   = 32,
    parameter int unsigned HISTORY_MAX = 8,
    parameter int unsigned TAG_MAX     = 30
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire btb_pkg::t_in_item   i_item,
    output logic                     empty,
    input  wire logic                pop,
    output btb_pkg::t_out_item       o_item,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_idx,
    input  wire logic [4:0]          i_cfg_data
);
    import btb_pkg::*;

    t_cfg     r_cfg;
    logic     clr;
    logic     f_valid, take, res_valid;
    t_in_item f_item;

    // any known register write clears the store
    assign clr = i_cfg_we && (i_cfg_idx != REG_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{btb_index_bits: 3'd0, history_size: 4'd1, tag_size: 5'd0,
                       fsm_reset: 2'd0, global_history: 1'b1, global_table: 1'b1,
                       share_mode: 2'd0};
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_INDEX_BITS:  r_cfg.btb_index_bits <= i_cfg_data[2:0];
                REG_HIST_SIZE:   r_cfg.history_size   <= i_cfg_data[3:0];
                REG_TAG_SIZE:    r_cfg.tag_size       <= i_cfg_data[4:0];
                REG_FSM_RESET:   r_cfg.fsm_reset      <= i_cfg_data[1:0];
                REG_GLOBAL_HIST: r_cfg.global_history <= i_cfg_data[0];
                REG_GLOBAL_TBL:  r_cfg.global_table   <= i_cfg_data[0];
                REG_SHARE_MODE:  r_cfg.share_mode     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    btb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(clr),
        .i_push(push), .o_full(full), .i_item(i_item),
        .o_valid(f_valid), .o_item(f_item), .i_take(take)
    );

    btb_back #(.BTB_DEPTH(BTB_DEPTH), .HISTORY_MAX(HISTORY_MAX), .TAG_MAX(TAG_MAX)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_clear(clr),
        .i_valid(f_valid), .i_item(f_item), .o_take(take),
        .o_res_valid(res_valid), .o_res(o_item), .i_res_pop(pop)
    );

    assign empty = !res_valid;

`ifndef SYNTHESIS
    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n || clr)
        (pop && !empty) |=> empty) else $error("result not drained");
    a_clr_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr |=> empty) else $error("result survives clear");
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty) else $error("result after reset");
`endif
endmodule
`default_nettype wire

[rtl/core/btb_front.sv]
// front end: input queue, holds up to two accepted transactions for the back end
// depends on btb_pkg
`default_nettype none
module btb_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_clear,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire btb_pkg::t_in_item i_item,
    output logic                   o_valid,
    output btb_pkg::t_in_item      o_item,
    input  wire logic              i_take
);
    import btb_pkg::*;

    // two-entry queue so the back end stalls on its own
    logic [1:0] r_cnt, n_cnt;
    logic       r_wp, r_rp;
    t_in_item   r_q [2];

    wire logic do_push = i_push && !o_full;
    wire logic do_pop  = i_take && o_valid;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_q[r_wp] <= i_item;
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers out of step");
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_clear)
        (o_full && !do_pop) |=> o_full) else $error("full dropped without pop");
`endif
endmodule
`default_nettype wire

[rtl/core/btb_back.sv]
// back end: btb lookup, counter read-modify-write, row and store clearing
// depends on btb_pkg
`default_nettype none
module btb_back #(
    parameter int unsigned BTB_DEPTH   = 32,
    parameter int unsigned HISTORY_MAX = 8,
    parameter int unsigned TAG_MAX     = 30
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire btb_pkg::t_cfg      i_cfg,
    input  wire logic               i_clear,
    input  wire logic               i_valid,
    input  wire btb_pkg::t_in_item  i_item,
    output logic                    o_take,
    output logic                    o_res_valid,
    output btb_pkg::t_out_item      o_res,
    input  wire logic               i_res_pop
);
    import btb_pkg::*;

    localparam int unsigned SW   = (BTB_DEPTH > 1) ? $clog2(BTB_DEPTH) : 1;
    localparam int unsigned HW   = HISTORY_MAX;
    localparam int unsigned ROW  = 1 << HW;
    localparam int unsigned CW   = SW + HW;
    localparam int unsigned CNT_DEPTH = BTB_DEPTH * ROW;
    localparam int unsigned TW   = TAG_MAX;
    localparam int unsigned SWEEP_W = $clog2(CNT_DEPTH + 1);

    t_back_state r_st, n_st;

    // btb entries in flops, counter table in memory
    logic [BTB_DEPTH-1:0] r_valid;
    logic [TW-1:0]        r_tag    [BTB_DEPTH];
    logic [PC_W-1:0]      r_target [BTB_DEPTH];
    logic [HW-1:0]        r_hist   [BTB_DEPTH];
    logic [2:0]           r_mem    [CNT_DEPTH];  // bit 2 marks written
    logic [2:0]           r_rd;

    logic [SWEEP_W-1:0] r_sweep;
    logic [HW-1:0]      r_rowcnt;
    t_in_item           r_it;
    logic [SW-1:0]      r_slot;
    logic [CW-1:0]      r_cidx;
    logic               r_hit;
    logic [31:0]        r_bcnt, r_fcnt;
    logic               r_ov;
    t_out_item          r_out;

    // configuration decode
    logic [2:0] ib;
    logic [3:0] hs;
    logic [4:0] ts;
    logic [HW-1:0] hmask;
    logic [SW-1:0] smask;
    logic [TW-1:0] tmask;
    always_comb begin
        ib = (i_cfg.btb_index_bits > 3'd5) ? 3'd5 : i_cfg.btb_index_bits;
        hs = (i_cfg.history_size == 4'd0) ? 4'd1 :
             ((i_cfg.history_size > 4'(HW)) ? 4'(HW) : i_cfg.history_size);
        ts = (i_cfg.tag_size > 5'(TW)) ? 5'(TW) : i_cfg.tag_size;
        hmask = HW'((32'd1 << hs) - 32'd1);
        smask = SW'((32'd1 << ib) - 32'd1);
        tmask = TW'((32'd1 << ts) - 32'd1);
    end

    // lookup of the head item
    logic [SW-1:0] slot, hslot;
    logic [TW-1:0] tag;
    logic          hit;
    logic [HW-1:0] hist, cx;
    logic [CW-1:0] cidx;
    always_comb begin
        slot  = i_item.branch_pc[2 +: SW] & smask;
        hslot = i_cfg.global_history ? '0 : slot;
        tag   = TW'(i_item.branch_pc[31:2]) & tmask;
        hit   = r_valid[slot] && (r_tag[slot] == tag);
        // a miss with local history reads zero history after the install
        hist  = (!hit && !i_cfg.global_history) ? '0 : (r_hist[hslot] & hmask);
        cx    = hist;
        case (i_cfg.share_mode)
            SHARE_LOW:  cx = (hist ^ i_item.branch_pc[2 +: HW]) & hmask;
            SHARE_HIGH: cx = (hist ^ i_item.branch_pc[16 +: HW]) & hmask;
            default:    cx = hist;
        endcase
        cidx = {(i_cfg.global_table ? SW'(0) : slot), cx};
    end

    // counter value after the registered read
    logic [1:0] cval;
    logic       ptaken, want_flush, rowclr;
    logic [PC_W-1:0] ptarget, want;
    logic [SW-1:0] ins_h;
    always_comb begin
        cval = r_rd[2] ? r_rd[1:0] : i_cfg.fsm_reset;
        ptaken  = r_hit && cval[1];
        ptarget = ptaken ? r_target[r_slot] : r_it.branch_pc + PC_STEP;
        want    = r_it.resolved_taken ? r_it.resolved_target : r_it.branch_pc + PC_STEP;
        want_flush = (r_it.operation == OP_UPDATE) && (ptarget != want);
        rowclr = (r_it.operation == OP_UPDATE) && !r_hit && !i_cfg.global_table;
        ins_h  = i_cfg.global_history ? '0 : r_slot;
    end

    // a local-table miss reads the row as reset, so the counter is fsm_reset
    logic [1:0] cuse, nuse;
    always_comb begin
        cuse = rowclr ? i_cfg.fsm_reset : cval;
        nuse = cuse;
        if (r_it.resolved_taken) begin
            if (cuse != 2'd3) nuse = cuse + 2'd1;
        end else begin
            if (cuse != 2'd0) nuse = cuse - 2'd1;
        end
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_SWEEP: if (r_sweep == SWEEP_W'(CNT_DEPTH - 1)) n_st = ST_IDLE;
            ST_IDLE:  if (i_valid && !r_ov) n_st = ST_READ;
            ST_READ:  n_st = (r_it.operation == OP_UPDATE) ?
                             (rowclr ? ST_ROWCLR : ST_WRITE) : ST_IDLE;
            ST_ROWCLR: if (r_rowcnt == HW'(ROW - 1)) n_st = ST_WRITE;
            ST_WRITE: n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
        if (i_clear) n_st = ST_SWEEP;
    end

    // outputs
    always_comb begin
        o_take = (r_st == ST_IDLE) && i_valid && !r_ov && !i_clear;
        o_res_valid = r_ov;
        o_res = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_SWEEP;
            r_sweep <= '0;
            r_valid <= '0;
            r_bcnt <= '0;
            r_fcnt <= '0;
            r_ov <= 1'b0;
            r_rowcnt <= '0;
        end else begin
            r_st <= n_st;
            if (r_ov && i_res_pop) r_ov <= 1'b0;
            if (i_clear) begin
                r_sweep <= '0;
                r_valid <= '0;
                r_bcnt <= '0;
                r_fcnt <= '0;
                r_ov <= 1'b0;
            end else begin
                case (r_st)
                    ST_SWEEP: r_sweep <= r_sweep + 1'b1;
                    ST_READ: begin
                        r_rowcnt <= '0;
                        r_ov <= 1'b1;
                        if (r_it.operation == OP_UPDATE) begin
                            r_bcnt <= r_bcnt + 32'd1;
                            if (want_flush) r_fcnt <= r_fcnt + 32'd1;
                            r_valid[r_slot] <= 1'b1;
                        end
                    end
                    ST_ROWCLR: r_rowcnt <= r_rowcnt + 1'b1;
                    default: ;
                endcase
            end
        end
    end

    // payload and memory
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_rd   <= r_mem[cidx];
            r_it   <= i_item;
            r_slot <= slot;
            r_hit  <= hit;
            r_cidx <= cidx;
        end
        if (r_st == ST_SWEEP) r_mem[CW'(r_sweep)] <= 3'b000;
        if (r_st == ST_ROWCLR) r_mem[{r_slot, r_rowcnt}] <= 3'b000;
        if (r_st == ST_WRITE) r_mem[r_cidx] <= {1'b1, nuse};
        if (r_st == ST_READ && r_it.operation == OP_UPDATE) begin
            r_tag[r_slot]    <= TW'(r_it.branch_pc[31:2]) & tmask;
            r_target[r_slot] <= r_it.resolved_target;
            r_out.branch_count <= r_bcnt + 32'd1;
            r_out.flush_count  <= r_fcnt + (want_flush ? 32'd1 : 32'd0);
            // trained counter uses history read before the shift
            if (!r_hit && !i_cfg.global_history)
                r_hist[r_slot] <= HW'({7'd0, r_it.resolved_taken}) & hmask;
            else
                r_hist[ins_h] <= {r_hist[ins_h][HW-2:0], r_it.resolved_taken} & hmask;
        end else if (r_st == ST_READ) begin
            r_out.branch_count <= r_bcnt;
            r_out.flush_count  <= r_fcnt;
        end
        if (r_st == ST_READ) begin
            r_out.predict_taken    <= ptaken;
            r_out.predicted_target <= ptarget;
            r_out.flush            <= want_flush;
        end
        if (r_st == ST_SWEEP) begin
            r_hist[SW'(r_sweep)] <= '0;
        end
    end

`ifndef SYNTHESIS
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> (r_st == ST_IDLE && !r_ov)) else $error("take while busy");
    a_read_res: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_clear)
        (r_st == ST_READ) |=> r_ov) else $error("no result after read");
    a_write_after: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_clear)
        (r_st == ST_WRITE) |-> ($past(r_st) == ST_READ || $past(r_st) == ST_ROWCLR))
        else $error("write out of sequence");
`endif
endmodule
`default_nettype wire

[tb/btb_predictor_scoreboard.sv]
// scoreboard class for the two-level branch predictor testbench
// depends on btb_pkg; holds its own copy of the btb, histories and counters
`timescale 1ns / 100ps
import btb_pkg::*;

class btb_predictor_scoreboard;
    t_cfg            cfg;
    bit              valid_q[32];
    bit [29:0]       tag_q[32];
    bit [31:0]       target_q[32];
    bit [7:0]        hist_q[32];
    bit [1:0]        ctr_q[8192];
    bit              ctr_written_q[8192];
    bit [31:0]       branches;
    bit [31:0]       flushes;
    t_out_item       expected_results[$];
    int              errors;
    int              checked;

    function new();
        cfg.btb_index_bits = 3'd0;
        cfg.history_size   = 4'd1;
        cfg.tag_size       = 5'd0;
        cfg.fsm_reset      = 2'd0;
        cfg.global_history = 1'b1;
        cfg.global_table   = 1'b1;
        cfg.share_mode     = SHARE_NONE;
        errors  = 0;
        checked = 0;
        clear_store();
    endfunction

    function void clear_store();
        for (int i = 0; i < 32; i++) begin
            valid_q[i] = 0;
            hist_q[i]  = 0;
        end
        for (int i = 0; i < 8192; i++) begin
            ctr_written_q[i] = 0;
        end
        branches = 0;
        flushes  = 0;
    endfunction

    function void write_reg(t_reg_idx r, logic [4:0] v);
        case (r)
            REG_INDEX_BITS:  cfg.btb_index_bits = v[2:0];
            REG_HIST_SIZE:   cfg.history_size   = v[3:0];
            REG_TAG_SIZE:    cfg.tag_size       = v[4:0];
            REG_FSM_RESET:   cfg.fsm_reset      = v[1:0];
            REG_GLOBAL_HIST: cfg.global_history = v[0];
            REG_GLOBAL_TBL:  cfg.global_table   = v[0];
            REG_SHARE_MODE:  cfg.share_mode     = v[1:0];
            default: return;
        endcase
        clear_store();
    endfunction

    function int unsigned hist_mask();
        int unsigned n;
        n = cfg.history_size;
        if (n < 1) n = 1;
        if (n > 8) n = 8;
        return (1 << n) - 1;
    endfunction

    function int unsigned slot_of(bit [31:0] pc);
        int unsigned b;
        b = cfg.btb_index_bits > 5 ? 5 : cfg.btb_index_bits;
        return (pc >> 2) & ((1 << b) - 1);
    endfunction

    function bit [29:0] tag_of(bit [31:0] pc);
        int unsigned n;
        n = cfg.tag_size > 30 ? 30 : cfg.tag_size;
        return (pc >> 2) & ((1 << n) - 1);
    endfunction

    function int unsigned ctr_index(bit [31:0] pc, int unsigned slot, bit [7:0] h);
        int unsigned m, row, idx;
        m   = hist_mask();
        row = cfg.global_table ? 0 : slot;
        idx = h & m;
        // mode 3 falls back to history only
        if (cfg.share_mode == SHARE_LOW) idx = (idx ^ (pc >> 2)) & m;
        else if (cfg.share_mode == SHARE_HIGH) idx = (idx ^ (pc >> 16)) & m;
        return row * 256 + (idx & 255);
    endfunction

    function bit [1:0] ctr_value(int unsigned c);
        return ctr_written_q[c] ? ctr_q[c] : cfg.fsm_reset;
    endfunction

    // predict, then apply the update side effects of one accepted transaction
    function void note_input(t_in_item it);
        t_out_item   r;
        int unsigned slot, hslot, c;
        bit [29:0]   t;
        bit [31:0]   want;
        bit [1:0]    v;
        slot  = slot_of(it.branch_pc);
        hslot = cfg.global_history ? 0 : slot;
        t     = tag_of(it.branch_pc);
        r.predict_taken    = 0;
        r.predicted_target = it.branch_pc + PC_STEP;
        r.flush            = 0;
        if (valid_q[slot] && tag_q[slot] == t &&
            ctr_value(ctr_index(it.branch_pc, slot, hist_q[hslot])) >= 2) begin
            r.predict_taken    = 1;
            r.predicted_target = target_q[slot];
        end
        if (it.operation == OP_UPDATE) begin
            want = it.resolved_taken ? it.resolved_target : it.branch_pc + PC_STEP;
            branches++;
            if (r.predicted_target != want) begin
                r.flush = 1;
                flushes++;
            end
            if (!valid_q[slot] || tag_q[slot] != t) begin
                valid_q[slot] = 1;
                tag_q[slot]   = t;
                if (!cfg.global_history) hist_q[slot] = 0;
                if (!cfg.global_table)
                    for (int i = 0; i < 256; i++) ctr_written_q[slot * 256 + i] = 0;
            end
            target_q[slot] = it.resolved_target;
            c = ctr_index(it.branch_pc, slot, hist_q[hslot]);
            hist_q[hslot] = ((hist_q[hslot] << 1) | it.resolved_taken) & hist_mask();
            v = ctr_value(c);
            if (it.resolved_taken) begin
                if (v < 3) v++;
            end else begin
                if (v > 0) v--;
            end
            ctr_q[c] = v;
            ctr_written_q[c] = 1;
        end
        r.branch_count = branches;
        r.flush_count  = flushes;
        expected_results.push_back(r);
    endfunction

    function void check_result(t_out_item got);
        t_out_item e;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        e = expected_results.pop_front();
        checked++;
        if (got.predict_taken !== e.predict_taken) begin
            $display("%0t: predict_taken exp %0d got %0d", $time, e.predict_taken,
                     got.predict_taken);
            errors++;
        end
        if (got.predicted_target !== e.predicted_target) begin
            $display("%0t: predicted_target exp %h got %h", $time, e.predicted_target,
                     got.predicted_target);
            errors++;
        end
        if (got.flush !== e.flush) begin
            $display("%0t: flush exp %0d got %0d", $time, e.flush, got.flush);
            errors++;
        end
        if (got.branch_count !== e.branch_count) begin
            $display("%0t: branch_count exp %0d got %0d", $time, e.branch_count,
                     got.branch_count);
            errors++;
        end
        if (got.flush_count !== e.flush_count) begin
            $display("%0t: flush_count exp %0d got %0d", $time, e.flush_count,
                     got.flush_count);
            errors++;
        end
    endfunction

    function int waiting();
        return expected_results.size();
    endfunction
endclass

[tb/tb_top.sv]
// top of the two-level branch predictor testbench: clock, reset, drivers, watchdog
// depends on btb_pkg, btb_predictor_scoreboard and the btb_two_level_branch_predictor rtl
`timescale 1ns / 100ps
import btb_pkg::*;

module tb_top;
    localparam int STALL_LIMIT = 40000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        push = 0;
    logic        full;
    t_in_item    i_item = '0;
    logic        empty;
    logic        pop = 0;
    t_out_item   o_item;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = REG_NONE;
    logic [4:0]  i_cfg_data = '0;

    btb_predictor_scoreboard sb = new();

    // idling allowed on both sides until the final phase
    bit          idle_on = 1;
    int          quiet_cycles = 0;
    int          items_sent = 0;

    // branch pool with fixed targets so most updates land on hits
    bit [31:0]   pool_pc[16];
    bit [31:0]   pool_tgt[16];
    bit          pool_bias[16];

    btb_two_level_branch_predictor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // watchdog: cycles without any accepted transaction on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("btb_two_level_branch_predictor: mismatch");
            $finish;
        end
    end

    // result side: check each popped transaction, stall in random bursts
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) sb.check_result(o_item);
            if (stall_left > 0) begin
                stall_left--;
                pop <= 0;
            end else if (idle_on && i_rst_n && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                pop <= 0;
            end else begin
                pop <= i_rst_n;
            end
        end
    end

    // one input transaction; optional sender gap first
    task automatic send_item(t_in_item it);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            push <= 0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        push   <= 1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_input(it);
        items_sent++;
    endtask

    // sender holds off until every expected result has come back
    task automatic drain();
        push <= 0;
        while (sb.waiting() != 0) @(posedge i_clk);
    endtask

    // register write only while idle: results drained first
    task automatic write_reg(t_reg_idx r, logic [4:0] v);
        drain();
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        i_cfg_we   <= 1;
        i_cfg_idx  <= r;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.write_reg(r, v);
        i_cfg_we   <= 0;
    endtask

    task automatic configure(logic [4:0] ib, logic [4:0] hs, logic [4:0] ts,
                             logic [4:0] fr, logic [4:0] gh, logic [4:0] gt,
                             logic [4:0] sm);
        write_reg(REG_INDEX_BITS, ib);
        write_reg(REG_HIST_SIZE, hs);
        write_reg(REG_TAG_SIZE, ts);
        write_reg(REG_FSM_RESET, fr);
        write_reg(REG_GLOBAL_HIST, gh);
        write_reg(REG_GLOBAL_TBL, gt);
        write_reg(REG_SHARE_MODE, sm);
    endtask

    function automatic t_in_item make_item(t_op op, bit [31:0] pc, bit [31:0] tgt, bit tk);
        t_in_item it;
        it.operation       = op;
        it.branch_pc       = pc;
        it.resolved_target = tgt;
        it.resolved_taken  = tk;
        return it;
    endfunction

    // new branch pool: some entries alias others in index but differ in tag
    task automatic fill_pool();
        for (int i = 0; i < 16; i++) begin
            if (i > 3 && $urandom_range(0, 2) == 0)
                pool_pc[i] = pool_pc[$urandom_range(0, i - 1)] ^ (32'd1 << $urandom_range(7, 31));
            else
                pool_pc[i] = $urandom;
            pool_tgt[i]  = $urandom;
            pool_bias[i] = $urandom_range(0, 1);
        end
    endtask

    // mostly well-formed branch streams from the pool, the rest pure noise
    task automatic random_items(int n);
        t_in_item it;
        int k;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) drain();
            if ($urandom_range(0, 9) < 7) begin
                k = $urandom_range(0, 15);
                it = make_item($urandom_range(0, 3) != 0 ? OP_UPDATE : OP_PREDICT,
                               pool_pc[k],
                               $urandom_range(0, 9) == 0 ? $urandom : pool_tgt[k],
                               $urandom_range(0, 4) == 0 ? !pool_bias[k] : pool_bias[k]);
            end else begin
                it = make_item(t_op'($urandom_range(0, 1)), $urandom, $urandom,
                               $urandom_range(0, 1));
            end
            send_item(it);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: defaults give one entry with an empty tag
        send_item(make_item(OP_PREDICT, 32'h0000_0000, 32'h0, 1'b0));
        send_item(make_item(OP_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
        send_item(make_item(OP_PREDICT, 32'h0000_0000, 32'h0, 1'b1));
        send_item(make_item(OP_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
        send_item(make_item(OP_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
        send_item(make_item(OP_PREDICT, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b0));
        send_item(make_item(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0));
        send_item(make_item(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0));
        send_item(make_item(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1));
        send_item(make_item(OP_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_item(make_item(OP_UPDATE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1));
        send_item(make_item(OP_UPDATE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
        send_item(make_item(OP_PREDICT, 32'h5555_5555, 32'h0, 1'b0));
        send_item(make_item(OP_UPDATE, 32'h1234_5678, 32'h1234_567C, 1'b1));
        fill_pool();
        random_items(150);

        // widest index, longest history and tag, per-entry history and table
        configure(5, 8, 30, 3, 0, 0, SHARE_HIGH);
        fill_pool();
        send_item(make_item(OP_UPDATE, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b0));
        send_item(make_item(OP_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0));
        random_items(190);

        // out-of-range values saturate; share mode from bit 2
        configure(7, 0, 31, 2, 1, 0, SHARE_LOW);
        fill_pool();
        random_items(190);

        // reserved share mode behaves as history only
        configure(3, 15, 10, 1, 0, 1, SHARE_RSVD);
        fill_pool();
        random_items(190);

        // unused register index leaves state alone
        configure(2, 4, 6, 0, 1, 1, SHARE_LOW);
        write_reg(REG_NONE, 5'd31);
        fill_pool();
        random_items(190);

        // last phase: no idling on either side
        configure(5, 3, 30, 2, 0, 0, SHARE_NONE);
        idle_on = 0;
        fill_pool();
        random_items(190);

        drain();
        repeat (20) @(posedge i_clk);
        $display("covered %0d transactions over six register settings, %0d results checked",
                 items_sent, sb.checked);
        if (sb.errors == 0 && sb.waiting() == 0) begin
            $display("btb_two_level_branch_predictor: match");
        end else begin
            $display("btb_two_level_branch_predictor: mismatch");
        end
        $finish;
    end
endmodule
